// ===== hw/rtl/resource_deadlock_detector_macros.svh =====
// Assertion helpers for the deadlock detector.
`ifndef RESOURCE_DEADLOCK_DETECTOR_MACROS_SVH
`define RESOURCE_DEADLOCK_DETECTOR_MACROS_SVH

// Same-cycle implication, sampled on clock, off during reset.
`define RDD_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication.
`define RDD_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== hw/rtl/rdd_pkg.sv =====
package rdd_pkg;

   localparam int MAX_CLIENTS_DEF   = 16;
   localparam int NUM_RESOURCES_DEF = 4;
   localparam int NUM_TOTALS        = 4;
   localparam logic [7:0] CNT_MAX   = 8'hFF;

   typedef enum logic [2:0] {
      CMD_ADD     = 3'd0,
      CMD_REQUEST = 3'd1,
      CMD_GRANT   = 3'd2,
      CMD_RELEASE = 3'd3,
      CMD_REMOVE  = 3'd4,
      CMD_DETECT  = 3'd5
   } cmd_type;

   typedef enum logic [2:0] {
      CELL_HOLD   = 3'd0,
      CELL_ROTATE = 3'd1,
      CELL_REMOVE = 3'd2,
      CELL_REQ    = 3'd3,
      CELL_GRANT  = 3'd4,
      CELL_REL    = 3'd5,
      CELL_INIT   = 3'd6
   } cell_op_type;

   typedef struct packed {
      cell_op_type op;
      logic [3:0]  client;
      logic [1:0]  resource;
   } cell_ctrl_type;

   typedef struct packed {
      logic [2:0] req_type;
      logic [3:0] client;
      logic [1:0] resource;
   } req_type_t_type;

   typedef struct packed {
      logic        deadlock_found;
      logic [15:0] stuck_mask;
      logic [4:0]  clients_in_use;
      logic        refused;
   } rsp_type;

endpackage

// ===== hw/rtl/rdd_cell.sv =====
module rdd_cell #(
   parameter int NUM_RESOURCES = 4,
   parameter int ROW           = 0
) (
   input  logic                           clock,
   input  logic                           reset,
   input  rdd_pkg::cell_ctrl_type         ctrl,
   input  logic [NUM_RESOURCES-1:0][7:0]  nb_req,
   input  logic [NUM_RESOURCES-1:0][7:0]  nb_held,
   input  logic                           nb_done,
   output logic [NUM_RESOURCES-1:0][7:0]  req,
   output logic [NUM_RESOURCES-1:0][7:0]  held,
   output logic                           done
);
   import rdd_pkg::*;

   logic [NUM_RESOURCES-1:0][7:0] req_ff, req_in, held_ff, held_in;
   logic done_ff, done_in;
   logic row_hit;

   assign row_hit = (ROW == int'(ctrl.client));

   always_comb begin
      req_in  = req_ff;
      held_in = held_ff;
      done_in = done_ff;
      unique case (ctrl.op)
         CELL_ROTATE: begin
            req_in  = nb_req;
            held_in = nb_held;
            done_in = nb_done;
         end
         CELL_REMOVE: begin
            if (ROW >= int'(ctrl.client)) begin
               req_in  = nb_req;
               held_in = nb_held;
            end
         end
         CELL_INIT: done_in = (req_ff == '0) || (held_ff == '0);
         CELL_REQ, CELL_GRANT, CELL_REL: begin
            for (int r = 0; r < NUM_RESOURCES; r++) begin
               if (row_hit && r == int'(ctrl.resource)) begin
                  if (ctrl.op == CELL_REQ) begin
                     if (req_ff[r] != CNT_MAX) req_in[r] = req_ff[r] + 8'd1;
                  end else if (ctrl.op == CELL_GRANT) begin
                     if (held_ff[r] != CNT_MAX) held_in[r] = held_ff[r] + 8'd1;
                     if (req_ff[r] != 8'd0) req_in[r] = req_ff[r] - 8'd1;
                  end else begin
                     if (held_ff[r] != 8'd0) held_in[r] = held_ff[r] - 8'd1;
                  end
               end
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         req_ff  <= '0;
         held_ff <= '0;
         done_ff <= 1'b0;
      end else begin
         req_ff  <= req_in;
         held_ff <= held_in;
         done_ff <= done_in;
      end
   end

   assign req  = req_ff;
   assign held = held_ff;
   assign done = done_ff;

endmodule

// ===== hw/rtl/resource_deadlock_detector.sv =====
// Resource deadlock detector: per-client request/held counts, banker-style check.
// Command channel: a transaction is taken when start is high and busy is low;
//   req_data carries req_type, client and resource.
// Result channel: rsp_valid strobes for one cycle with rsp_data; exactly one
//   result per command. The receiver cannot stall, so nothing is held back.
// Config: csr_we writes csr_wdata into total register csr_index at once.
// Simple commands (add/request/grant/release/remove): the result shows in the cycle
//   after the command, and the next command may enter then.
// Detect: the sequencer steps through SUM, P scan passes and FIN, P being the number
//   of scan passes (1 to live clients + 1). The rows sit in a ring of cells that rotates
//   one row per cycle past the head cell; one pass sums held columns, then
//   each pass finishes fitting clients, until a pass makes no progress.
// Reset: all counts, totals and the client count clear; no sweep needed.
module resource_deadlock_detector #(
   parameter int MAX_CLIENTS   = rdd_pkg::MAX_CLIENTS_DEF,
   parameter int NUM_RESOURCES = rdd_pkg::NUM_RESOURCES_DEF
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    start,
   output logic                    busy,
   input  rdd_pkg::req_type_t_type req_data,
   output logic                    rsp_valid,
   output rdd_pkg::rsp_type        rsp_data,
   input  logic                    csr_we,
   input  logic [1:0]              csr_index,
   input  logic [7:0]              csr_wdata
);
   import rdd_pkg::*;
`include "resource_deadlock_detector_macros.svh"

   localparam int AW = $clog2(MAX_CLIENTS + 1);
   localparam int PW = $clog2(MAX_CLIENTS);
   localparam int WW = 8 + $clog2(MAX_CLIENTS) + 2;

   typedef enum logic [3:0] {
      ST_IDLE = 4'b0001,
      ST_SUM  = 4'b0010,
      ST_SCAN = 4'b0100,
      ST_FIN  = 4'b1000
   } state_type;

   state_type state_ff, state_in;
   logic [7:0] total_ff [NUM_TOTALS];
   logic signed [WW-1:0] work_ff [NUM_RESOURCES];
   logic signed [WW-1:0] work_in [NUM_RESOURCES];
   logic [PW-1:0] cnt_ff, cnt_in;
   logic progress_ff, progress_in;
   logic [1:0] stuck_ff, stuck_in;   // saturates at 2
   logic [AW-1:0] active_ff, active_in;
   logic rsp_valid_ff, rsp_valid_in;
   rsp_type rsp_ff, rsp_in;
   cell_ctrl_type ctrl;

   // ring of row cells; cell 0 is the head examined by the sequencer
   logic [NUM_RESOURCES-1:0][7:0] row_req  [MAX_CLIENTS];
   logic [NUM_RESOURCES-1:0][7:0] row_held [MAX_CLIENTS];
   logic                          row_done [MAX_CLIENTS];
   logic [NUM_RESOURCES-1:0][7:0] wrap_req, wrap_held;
   logic wrap_done;
   logic [15:0] stuck_vec;
   logic row_ok, res_ok, fits, last_step;
   logic cmd_simple, refused_bad;

   for (genvar i = 0; i < MAX_CLIENTS; i++) begin : g_cell
      if (i == MAX_CLIENTS - 1) begin : g_tail
         rdd_cell #(.NUM_RESOURCES(NUM_RESOURCES), .ROW(i)) u_cell (
            .clock, .reset, .ctrl,
            .nb_req(wrap_req), .nb_held(wrap_held), .nb_done(wrap_done),
            .req(row_req[i]), .held(row_held[i]), .done(row_done[i]));
      end else begin : g_body
         rdd_cell #(.NUM_RESOURCES(NUM_RESOURCES), .ROW(i)) u_cell (
            .clock, .reset, .ctrl,
            .nb_req(row_req[i+1]), .nb_held(row_held[i+1]), .nb_done(row_done[i+1]),
            .req(row_req[i]), .held(row_held[i]), .done(row_done[i]));
      end
   end

   // only the first 16 rows show in the mask
   for (genvar i = 0; i < 16; i++) begin : g_mask
      if (i < MAX_CLIENTS) begin : g_on
         assign stuck_vec[i] = !row_done[i];
      end else begin : g_off
         assign stuck_vec[i] = 1'b0;
      end
   end

   assign row_ok    = int'(req_data.client) < int'(active_ff);
   assign res_ok    = int'(req_data.resource) < NUM_RESOURCES;
   assign last_step = (cnt_ff == PW'(MAX_CLIENTS - 1));

   // head row fits when it is open and every request is within work
   always_comb begin
      fits = !row_done[0];
      for (int r = 0; r < NUM_RESOURCES; r++) begin
         if ($signed({{(WW-8){1'b0}}, row_req[0][r]}) > work_ff[r]) fits = 1'b0;
      end
   end

   always_comb begin
      state_in      = state_ff;
      work_in       = work_ff;
      cnt_in        = cnt_ff;
      progress_in   = progress_ff;
      stuck_in      = stuck_ff;
      active_in     = active_ff;
      rsp_valid_in  = 1'b0;
      rsp_in        = rsp_ff;
      ctrl.op       = CELL_HOLD;
      ctrl.client   = req_data.client;
      ctrl.resource = req_data.resource;
      wrap_req      = row_req[0];
      wrap_held     = row_held[0];
      wrap_done     = row_done[0];

      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               rsp_in       = '0;
               rsp_valid_in = 1'b1;
               unique case (req_data.req_type)
                  CMD_ADD: begin
                     if (active_ff == AW'(MAX_CLIENTS)) rsp_in.refused = 1'b1;
                     else active_in = active_ff + AW'(1);
                  end
                  CMD_REQUEST, CMD_GRANT, CMD_RELEASE: begin
                     if (!row_ok || !res_ok) begin
                        rsp_in.refused = 1'b1;
                     end else if (req_data.req_type == CMD_REQUEST) begin
                        ctrl.op = CELL_REQ;
                     end else if (req_data.req_type == CMD_GRANT) begin
                        ctrl.op = CELL_GRANT;
                     end else begin
                        ctrl.op = CELL_REL;
                     end
                  end
                  CMD_REMOVE: begin
                     if (!row_ok) begin
                        rsp_in.refused = 1'b1;
                     end else begin
                        // rows at and after the client move up; tail clears
                        ctrl.op   = CELL_REMOVE;
                        wrap_req  = '0;
                        wrap_held = '0;
                        active_in = active_ff - AW'(1);
                     end
                  end
                  CMD_DETECT: begin
                     rsp_valid_in = 1'b0;
                     ctrl.op      = CELL_INIT;
                     for (int r = 0; r < NUM_RESOURCES; r++) begin
                        if (r < NUM_TOTALS) work_in[r] = $signed(WW'(total_ff[2'(r)]));
                        else work_in[r] = '0;
                     end
                     cnt_in   = '0;
                     state_in = ST_SUM;
                  end
                  default: rsp_in.refused = 1'b1;
               endcase
               rsp_in.clients_in_use = 5'(active_in);
            end
         end
         ST_SUM: begin
            // one full turn: subtract each row's holdings
            ctrl.op = CELL_ROTATE;
            for (int r = 0; r < NUM_RESOURCES; r++) begin
               work_in[r] = work_ff[r] - $signed({{(WW-8){1'b0}}, row_held[0][r]});
            end
            cnt_in = cnt_ff + PW'(1);
            if (last_step) begin
               cnt_in      = '0;
               progress_in = 1'b0;
               stuck_in    = '0;
               state_in    = ST_SCAN;
            end
         end
         ST_SCAN: begin
            ctrl.op   = CELL_ROTATE;
            wrap_done = row_done[0] | fits;
            if (fits) begin
               progress_in = 1'b1;
               for (int r = 0; r < NUM_RESOURCES; r++) begin
                  work_in[r] = work_ff[r] + $signed({{(WW-8){1'b0}}, row_held[0][r]});
               end
            end else if (!row_done[0] && stuck_ff != 2'd2) begin
               stuck_in = stuck_ff + 2'd1;
            end
            cnt_in = cnt_ff + PW'(1);
            if (last_step) begin
               cnt_in = '0;
               if (progress_in) begin
                  progress_in = 1'b0;
                  stuck_in    = '0;
               end else begin
                  state_in = ST_FIN;
               end
            end
         end
         ST_FIN: begin
            // ring is back in place; last pass made no progress
            rsp_valid_in          = 1'b1;
            rsp_in.deadlock_found = (stuck_ff == 2'd2);
            rsp_in.stuck_mask     = stuck_vec;
            rsp_in.clients_in_use = 5'(active_ff);
            rsp_in.refused        = 1'b0;
            state_in              = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         active_ff    <= '0;
         rsp_valid_ff <= 1'b0;
         cnt_ff       <= '0;
         progress_ff  <= 1'b0;
         stuck_ff     <= '0;
         for (int t = 0; t < NUM_TOTALS; t++) total_ff[t] <= '0;
      end else begin
         state_ff     <= state_in;
         active_ff    <= active_in;
         rsp_valid_ff <= rsp_valid_in;
         cnt_ff       <= cnt_in;
         progress_ff  <= progress_in;
         stuck_ff     <= stuck_in;
         if (csr_we) total_ff[csr_index] <= csr_wdata;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff  <= rsp_in;
      work_ff <= work_in;
   end

   assign busy      = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   assign cmd_simple  = start && !busy && (req_data.req_type != CMD_DETECT);
   assign refused_bad = rsp_valid && rsp_data.refused &&
                        (rsp_data.deadlock_found || (rsp_data.stuck_mask != 16'd0));

   `RDD_ASSERT_NEXT(a_cmd_rsp, cmd_simple, rsp_valid, "simple command lost its result")
   `RDD_ASSERT_NOW(a_active_range, 1'b1, active_ff <= AW'(MAX_CLIENTS), "client count too big")
   `RDD_ASSERT_NOW(a_refused_clean, 1'b1, !refused_bad, "refused result flags deadlock")

endmodule
